// ===== rtl/core/text_mode_character_writer_defines.svh =====
// Assertion macros shared by the text-mode character writer RTL.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef TEXT_MODE_CHARACTER_WRITER_DEFINES_SVH
`define TEXT_MODE_CHARACTER_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tmcw_pkg.sv =====
// Shared types and constants of the text-mode character writer.
// No dependencies; used by the top level, tmcw_cfg and tmcw_ctrl.
`timescale 1ns / 1ps

package tmcw_pkg;

	// Action codes of an input request.
	localparam logic [1:0] ACT_PUT         = 2'd0;
	localparam logic [1:0] ACT_DELETE      = 2'd1;
	localparam logic [1:0] ACT_HIGHLIGHT   = 2'd2;
	localparam logic [1:0] ACT_UNHIGHLIGHT = 2'd3;

	// Configuration register indexes.
	localparam logic REG_FOREGROUND = 1'b0;
	localparam logic REG_BACKGROUND = 1'b1;

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] ATTR_INVERSE = 8'hF0;
	localparam logic [7:0] ATTR_NORMAL  = 8'h0F;

	localparam logic [3:0] FOREGROUND_RESET = 4'd15;
	localparam logic [3:0] BACKGROUND_RESET = 4'd0;

	// Width of linear cell index arithmetic; covers the largest screen.
	localparam int IDX_W = 12;

	typedef struct packed {
		logic       clearing;
		logic       executing;
		logic [4:0] row;
		logic [6:0] column;
	} tmcw_status_t;

endpackage

// ===== rtl/core/tmcw_if.sv =====
// Request and result channel interfaces of the text-mode character writer.
// Depends on nothing; used by the controller and the top level.
`timescale 1ns / 1ps

interface tmcw_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] char_code;
	logic [6:0] cursor_x;
	logic [4:0] cursor_y;

	modport source (output valid, action, char_code, cursor_x, cursor_y, input ready);
	modport sink (input valid, action, char_code, cursor_x, cursor_y, output ready);
endinterface

interface tmcw_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  row_now;
	logic [6:0]  column_now;
	logic [10:0] cell_index;
	logic [15:0] cell_word;
	logic        wrote_cell;
	logic        screen_cleared;
	logic        request_ignored;

	modport source (output valid, row_now, column_now, cell_index, cell_word, wrote_cell,
		screen_cleared, request_ignored, input ready);
	modport sink (input valid, row_now, column_now, cell_index, cell_word, wrote_cell,
		screen_cleared, request_ignored, output ready);
endinterface

// ===== rtl/core/text_mode_character_writer.sv =====
// Text-mode character writer: ROWS x COLUMNS screen of 16-bit cells with a cursor.
// Requests enter on in_ch, one result per request leaves on out_ch (valid/ready).
// Colors are set through the APB-style port: foreground at 0x0, background at 0x4.
// A request is taken only when the block is idle; a highlight reads the screen
// memory in the cycle it is taken, and the cell is written back and the result
// registered from the execute state that follows, which waits while a stalled
// result holds the output. The registered read data of the screen memory sets
// this order.
// A request that runs past the last row clears the screen: its result is
// delivered at once, but no new request is taken while every cell is
// rewritten, one cell per cycle.
// After reset the same sweep fills the memory with white-on-black spaces
// before the first request is taken; color writes are accepted throughout.
// A stalled receiver holds the result register; a new request can still be
// taken, but it waits in its execute cycle until the result slot is free.
`timescale 1ns / 1ps
`include "text_mode_character_writer_defines.svh"

module text_mode_character_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	tmcw_in_if.sink     in_ch,
	tmcw_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]             attr;
	tmcw_pkg::tmcw_status_t status;

	tmcw_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.attr(attr)
	);

	tmcw_ctrl #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.attr(attr),
		.status(status)
	);

	`TMCW_ASSERT_NEXT(a_one_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready && status.executing, "request taken while another is in flight")
	`TMCW_ASSERT_NOW(a_no_take_in_sweep, status.clearing, !in_ch.ready, "request taken during clearing sweep")
	`TMCW_ASSERT_NOW(a_cursor_range, in_ch.ready, (status.row < ROWS) && (status.column < COLUMNS), "cursor outside the screen")

endmodule

// ===== rtl/core/tmcw_screen_ram.sv =====
// Screen memory: one write port and one read port with registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module tmcw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/tmcw_cfg.sv =====
// APB-style register file holding the foreground and background colors.
// Depends on tmcw_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module tmcw_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  attr
);

	logic [3:0] fg_q;
	logic [3:0] bg_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// The low address bits select a byte inside the word and are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tmcw_pkg::FOREGROUND_RESET;
			bg_q <= tmcw_pkg::BACKGROUND_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				tmcw_pkg::REG_FOREGROUND: fg_q <= pwdata[3:0];
				tmcw_pkg::REG_BACKGROUND: bg_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			tmcw_pkg::REG_FOREGROUND: prdata = {28'd0, fg_q};
			tmcw_pkg::REG_BACKGROUND: prdata = {28'd0, bg_q};
			default: prdata = 32'd0;
		endcase
	end

	assign attr = {bg_q, fg_q};

endmodule

// ===== rtl/core/tmcw_ctrl.sv =====
// Request sequencer: cursor, read-modify-write of screen cells, clearing sweep.
// Depends on tmcw_pkg, the channel interfaces and tmcw_screen_ram.
`timescale 1ns / 1ps

module tmcw_ctrl #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tmcw_in_if.sink               in_ch,
	tmcw_out_if.source            out_ch,
	input  logic [7:0]            attr,
	output tmcw_pkg::tmcw_status_t status
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW = $clog2(CELLS);
	localparam int IW = tmcw_pkg::IDX_W;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	function automatic logic [IW-1:0] lin_idx(input logic [4:0] r, input logic [6:0] c);
		return IW'(r) * IW'(COLUMNS) + IW'(c);
	endfunction

	logic [1:0]    state_q;
	logic [AW-1:0] clr_addr_q;
	logic [15:0]   clr_word_q;
	logic [4:0]    row_q;
	logic [6:0]    col_q;

	logic [1:0]    action_s1;
	logic [7:0]    char_s1;
	logic [6:0]    x_s1;
	logic [4:0]    y_s1;

	logic          out_valid_q;
	logic [4:0]    out_row_q;
	logic [6:0]    out_col_q;
	logic [10:0]   out_idx_q;
	logic [15:0]   out_word_q;
	logic          out_wrote_q;
	logic          out_clr_q;
	logic          out_ign_q;

	logic          accept;
	logic          in_hl;
	logic          in_range;
	logic [IW-1:0] rd_idx;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [15:0]   ram_rdata;
	logic          advance;

	logic [5:0]    row_inc;
	logic [7:0]    col_inc;
	logic          row_wrap;
	logic          col_wrap;
	logic [4:0]    row_nx;
	logic [6:0]    col_nx;
	logic [4:0]    op_r;
	logic [6:0]    op_c;
	logic [15:0]   word_nx;
	logic          wrote_nx;
	logic          clr_nx;
	logic          ign_nx;
	logic [IW-1:0] idx_nx;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// A highlight reads its cell as the request is taken; the data is ready
	// in the execute cycle. Writes land before the next request can read.
	assign in_hl = (in_ch.action == tmcw_pkg::ACT_HIGHLIGHT) ||
		(in_ch.action == tmcw_pkg::ACT_UNHIGHLIGHT);
	assign in_range = ({1'b0, in_ch.cursor_x} < 8'(COLUMNS)) &&
		({1'b0, in_ch.cursor_y} < 6'(ROWS));
	assign rd_idx = lin_idx(in_ch.cursor_y, in_ch.cursor_x);

	assign advance = (state_q == ST_EXEC) && (!out_valid_q || out_ch.ready);

	assign row_inc  = {1'b0, row_q} + 6'd1;
	assign col_inc  = {1'b0, col_q} + 8'd1;
	assign row_wrap = (row_inc >= 6'(ROWS));
	assign col_wrap = (col_inc >= 8'(COLUMNS));

	always_comb begin
		row_nx   = row_q;
		col_nx   = col_q;
		op_r     = row_q;
		op_c     = col_q;
		word_nx  = 16'd0;
		wrote_nx = 1'b0;
		clr_nx   = 1'b0;
		ign_nx   = 1'b0;
		case (action_s1)
			tmcw_pkg::ACT_PUT: begin
				if (char_s1 == tmcw_pkg::NEWLINE_CODE) begin
					col_nx = 7'd0;
					clr_nx = row_wrap;
					row_nx = row_inc[4:0];
				end else begin
					wrote_nx = 1'b1;
					word_nx  = {attr, char_s1};
					if (col_wrap) begin
						col_nx = 7'd0;
						clr_nx = row_wrap;
						row_nx = row_inc[4:0];
					end else begin
						col_nx = col_inc[6:0];
					end
				end
				if (clr_nx) begin
					row_nx = 5'd0;
					col_nx = 7'd0;
				end
			end
			tmcw_pkg::ACT_DELETE: begin
				if (row_q == 5'd0 && col_q == 7'd0) begin
					ign_nx = 1'b1;
				end else begin
					wrote_nx = 1'b1;
					if (col_q == 7'd0) begin
						row_nx = row_q - 5'd1;
						col_nx = 7'(COLUMNS - 1);
					end else begin
						col_nx = col_q - 7'd1;
					end
					op_r = row_nx;
					op_c = col_nx;
				end
			end
			default: begin
				op_r = y_s1;
				op_c = x_s1;
				if (({1'b0, x_s1} >= 8'(COLUMNS)) || ({1'b0, y_s1} >= 6'(ROWS))) begin
					ign_nx = 1'b1;
				end else begin
					wrote_nx = 1'b1;
					if (action_s1 == tmcw_pkg::ACT_HIGHLIGHT) begin
						word_nx = {tmcw_pkg::ATTR_INVERSE, ram_rdata[7:0]};
					end else begin
						word_nx = {tmcw_pkg::ATTR_NORMAL, ram_rdata[7:0]};
					end
				end
			end
		endcase
		idx_nx = wrote_nx ? lin_idx(op_r, op_c) : '0;
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = clr_word_q;
		end else begin
			ram_we    = advance && wrote_nx;
			ram_waddr = idx_nx[AW-1:0];
			ram_wdata = word_nx;
		end
	end

	tmcw_screen_ram #(
		.DEPTH(CELLS),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(accept && in_hl && in_range),
		.raddr(rd_idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	// After reset the sweep writes the power-on cell value to every entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			clr_word_q <= {tmcw_pkg::ATTR_NORMAL, tmcw_pkg::SPACE_CODE};
			row_q      <= 5'd0;
			col_q      <= 7'd0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_addr_q <= clr_addr_q + AW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (advance) begin
						row_q <= row_nx;
						col_q <= col_nx;
						if (clr_nx) begin
							state_q    <= ST_CLEAR;
							clr_addr_q <= '0;
							clr_word_q <= {attr, tmcw_pkg::SPACE_CODE};
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= in_ch.action;
			char_s1   <= in_ch.char_code;
			x_s1      <= in_ch.cursor_x;
			y_s1      <= in_ch.cursor_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_row_q   <= row_nx;
			out_col_q   <= col_nx;
			out_idx_q   <= idx_nx[10:0];
			out_word_q  <= word_nx;
			out_wrote_q <= wrote_nx;
			out_clr_q   <= clr_nx;
			out_ign_q   <= ign_nx;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.row_now         = out_row_q;
	assign out_ch.column_now      = out_col_q;
	assign out_ch.cell_index      = out_idx_q;
	assign out_ch.cell_word       = out_word_q;
	assign out_ch.wrote_cell      = out_wrote_q;
	assign out_ch.screen_cleared  = out_clr_q;
	assign out_ch.request_ignored = out_ign_q;

	assign status.clearing  = (state_q == ST_CLEAR);
	assign status.executing = (state_q == ST_EXEC);
	assign status.row       = row_q;
	assign status.column    = col_q;

endmodule
